@@ sv/swrs_pkg.sv @@
package swrs_pkg;

    // Stack geometry.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field widths on the ports.
    localparam int REQ_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_F_W = 5;
    localparam int S_DATA_W  = 32;
    localparam int S_USER_W  = 8;
    localparam int M_DATA_W  = 48;

    // Request kinds.
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH    = 3'd0,
        REQ_MOVE    = 3'd1,
        REQ_POP     = 3'd2,
        REQ_POP_AUX = 3'd3,
        REQ_CLEAR   = 3'd4
    } req_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_MAIN_EMPTY = 2'd1,
        STAT_AUX_EMPTY  = 2'd2,
        STAT_FULL       = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic read;
        logic exec;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Low DATA_WIDTH bits of an incoming value.
    function automatic logic [DATA_WIDTH-1:0] to_entry(input logic [VALUE_W-1:0] v);
        logic [DATA_WIDTH+VALUE_W-1:0] tmp;
        tmp = {{DATA_WIDTH{1'b0}}, v};
        return tmp[DATA_WIDTH-1:0];
    endfunction

    // Low 32 bits of a stored entry.
    function automatic logic [VALUE_W-1:0] to_value(input logic [DATA_WIDTH-1:0] e);
        logic [DATA_WIDTH+VALUE_W-1:0] tmp;
        tmp = {{VALUE_W{1'b0}}, e};
        return tmp[VALUE_W-1:0];
    endfunction

    // Low five bits of a stack count.
    function automatic logic [DEPTH_F_W-1:0] to_depth(input logic [CNT_W-1:0] c);
        logic [CNT_W+DEPTH_F_W-1:0] tmp;
        tmp = {{DEPTH_F_W{1'b0}}, c};
        return tmp[DEPTH_F_W-1:0];
    endfunction

endpackage

@@ sv/swrs_ctrl.sv @@
module swrs_ctrl
    import swrs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands; no item is taken while reset is held.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (dp_status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/swrs_datapath.sv @@
module swrs_datapath
    import swrs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          dp_status,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    // Stack memories.
    logic [DATA_WIDTH-1:0] main_mem [DEPTH];
    logic [DATA_WIDTH-1:0] aux_mem  [DEPTH];

    req_t                  req_reg;
    logic [DATA_WIDTH-1:0] push_reg;
    logic [CNT_W-1:0]      main_cnt_reg;
    logic [CNT_W-1:0]      main_cnt_next;
    logic [CNT_W-1:0]      aux_cnt_reg;
    logic [CNT_W-1:0]      aux_cnt_next;
    logic [DATA_WIDTH-1:0] main_rd_reg;
    logic [DATA_WIDTH-1:0] aux_rd_reg;
    logic [CNT_W-1:0]      main_top;
    logic [CNT_W-1:0]      aux_top;
    logic                  main_we;
    logic                  aux_we;
    logic [DATA_WIDTH-1:0] main_wdata;
    logic                  main_full;
    logic                  aux_full;
    logic                  main_empty;
    logic                  aux_empty;
    status_t               stat;
    logic [VALUE_W-1:0]    popped;
    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg;

    // Capture the request item.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= req_t'(s_tuser[REQ_W-1:0]);
            push_reg <= to_entry(s_tdata[VALUE_W-1:0]);
        end
    end

    // Read both stack tops; the counts hold until the request executes.
    assign main_top = main_cnt_reg - ONE_CNT;
    assign aux_top  = aux_cnt_reg - ONE_CNT;

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            main_rd_reg <= main_mem[main_top[ADDR_W-1:0]];
            aux_rd_reg  <= aux_mem[aux_top[ADDR_W-1:0]];
        end
    end

    assign main_full  = (main_cnt_reg >= DEPTH_CNT);
    assign aux_full   = (aux_cnt_reg >= DEPTH_CNT);
    assign main_empty = (main_cnt_reg == '0);
    assign aux_empty  = (aux_cnt_reg == '0);

    // Decide the effect of the request.
    always_comb begin
        main_cnt_next = main_cnt_reg;
        aux_cnt_next  = aux_cnt_reg;
        main_we       = 1'b0;
        aux_we        = 1'b0;
        main_wdata    = push_reg;
        stat          = STAT_OK;
        popped        = '0;
        case (req_reg)
            REQ_PUSH: begin
                if (main_full) begin
                    stat = STAT_FULL;
                end else begin
                    main_we       = 1'b1;
                    main_cnt_next = main_cnt_reg + ONE_CNT;
                end
            end
            REQ_MOVE: begin
                if (aux_empty) begin
                    stat = STAT_AUX_EMPTY;
                end else if (main_full) begin
                    stat = STAT_FULL;
                end else begin
                    main_we       = 1'b1;
                    main_wdata    = aux_rd_reg;
                    main_cnt_next = main_cnt_reg + ONE_CNT;
                    aux_cnt_next  = aux_cnt_reg - ONE_CNT;
                end
            end
            REQ_POP: begin
                if (main_empty) begin
                    stat = STAT_MAIN_EMPTY;
                end else begin
                    popped        = to_value(main_rd_reg);
                    main_cnt_next = main_cnt_reg - ONE_CNT;
                end
            end
            REQ_POP_AUX: begin
                if (main_empty) begin
                    stat = STAT_MAIN_EMPTY;
                end else if (aux_full) begin
                    stat = STAT_FULL;
                end else begin
                    popped        = to_value(main_rd_reg);
                    aux_we        = 1'b1;
                    main_cnt_next = main_cnt_reg - ONE_CNT;
                    aux_cnt_next  = aux_cnt_reg + ONE_CNT;
                end
            end
            REQ_CLEAR: begin
                main_cnt_next = '0;
                aux_cnt_next  = '0;
            end
            default: begin
            end
        endcase
    end

    // Memory writes land at the current count of each stack.
    always_ff @(posedge aclk) begin
        if (cmd.exec && main_we) begin
            main_mem[main_cnt_reg[ADDR_W-1:0]] <= main_wdata;
        end
        if (cmd.exec && aux_we) begin
            aux_mem[aux_cnt_reg[ADDR_W-1:0]] <= main_rd_reg;
        end
    end

    // Stack counts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_cnt_reg <= '0;
            aux_cnt_reg  <= '0;
        end else if (cmd.exec) begin
            main_cnt_reg <= main_cnt_next;
            aux_cnt_reg  <= aux_cnt_next;
        end
    end

    // Output register holds one result item until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_data_reg <= {4'b0000, to_depth(aux_cnt_next), to_depth(main_cnt_next),
                             stat, popped};
        end
    end

    assign dp_status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // Counts never pass the stack depth.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_cnt_reg <= DEPTH_CNT) && (aux_cnt_reg <= DEPTH_CNT))
        else $error("stack count beyond depth");

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    // A successful push grows main by exactly one.
    a_push_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && req_reg == REQ_PUSH && !main_full)
        |=> (main_cnt_reg == $past(main_cnt_reg) + ONE_CNT))
        else $error("push did not grow main stack");

    // A pop to aux keeps the total number of entries.
    a_pop_aux_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && req_reg == REQ_POP_AUX)
        |=> ((main_cnt_reg + aux_cnt_reg) == ($past(main_cnt_reg) + $past(aux_cnt_reg))))
        else $error("pop to aux lost or made an entry");
`endif

endmodule

@@ sv/stack_with_recycle_stack_core.sv @@
// Dual LIFO stack core: a main stack and an auxiliary stack of DEPTH entries each.
// Each request item is accepted, then the stack tops are read into registers, then the
// update executes and loads the result register. A new request item is taken only after
// the last one has executed. A result waiting at the output holds the update step,
// so only one more request item is taken behind it until the result is taken.
// Reset (aresetn low, synchronous) empties both stacks and drops a pending result;
// stack memories are not cleared, since a value read is used only after it was written.
module stack_with_recycle_stack_core
    import swrs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // [31:0] push_value
    input  logic [S_USER_W-1:0] s_tuser,  // [2:0] req_type, [7:3] zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // [31:0] pop_value, [33:32] status,
                                          // [38:34] main_depth, [43:39] aux_depth, [47:44] zero
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // Sequencer for each request item.
    swrs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // Stacks, counts and output register.
    swrs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .dp_status (dp_status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
